// ===== design/gcs_pkg.sv =====
`default_nettype none
package gcs_pkg;

  localparam int WBITS = 30;
  localparam logic [30:0] ONE_W = 31'(64'(1) << WBITS);
  localparam logic [63:0] HALF_W = 64'(1) << (WBITS - 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 3'd5;

  // Corner number of the eighth corner of an atom.
  localparam logic [2:0] LAST_CNR = 3'd7;

  typedef struct packed {
    logic signed [31:0] atom_x;
    logic signed [31:0] atom_y;
    logic signed [31:0] atom_z;
    logic signed [31:0] atom_charge;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        corner_i;
    logic [10:0]        corner_j;
    logic [10:0]        corner_k;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic signed [31:0] corner_share;
    logic               last_corner;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/gcs_axis.sv =====
`default_nettype none
module gcs_axis
  import gcs_pkg::*;
#(
  parameter int GRID_DIM = 1024,
  localparam int QB = $clog2(GRID_DIM),
  localparam int BW = QB + 33
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [31:0]   pos,
  input  logic signed [31:0]   org,
  input  logic [30:0]          spc,
  output logic [QB-1:0]        qf_o,
  output logic signed [BW-1:0] base_o,
  output logic [30:0]          frac_o
);

  localparam int QW = QB + 1;
  localparam int RW = QB + 34;
  localparam int PW = QB + 31;
  localparam int AW = QB + 34;
  localparam int NW = QB + 36;
  localparam int KW = $clog2(NW - 31);
  localparam int FW = 63;
  localparam int FQ = 31;
  localparam logic [QW-1:0] QMAX = QW'(GRID_DIM - 2);

  // Cell index: restoring division, one quotient bit per stage, top bit flags overflow.
  logic [RW-1:0]      rem_r [QW];
  logic [QW-1:0]      quo_r [QW+1];
  logic               neg_r [QW+1];
  logic signed [32:0] dif_r [QW+1];
  logic signed [32:0] diff_c;

  assign diff_c = {pos[31], pos} - {org[31], org};

  always_ff @(posedge clk) begin
    if (adv) begin
      dif_r[0] <= diff_c;
      neg_r[0] <= diff_c[32];
      quo_r[0] <= '0;
      rem_r[0] <= diff_c[32] ? '0 : RW'(diff_c[31:0]);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int B = QW - j;
    logic [RW-1:0] sub;
    logic          ge;
    assign sub = RW'(spc) << B;
    assign ge  = rem_r[j-1] >= sub;
    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[j] <= ge ? (quo_r[j-1] | (QW'(1) << B)) : quo_r[j-1];
        neg_r[j] <= neg_r[j-1];
        dif_r[j] <= dif_r[j-1];
      end
    end
    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j] <= ge ? rem_r[j-1] - sub : rem_r[j-1];
        end
      end
    end
  end

  logic [QB-1:0]        qf_c_r, qf_p_r, qf_o_r, qf_n_r, qf_d_r, qf_k_r;
  logic signed [32:0]   dif_c_r, dif_p_r;
  logic [PW-1:0]        prod_r;
  logic signed [AW-1:0] a0_r;
  logic signed [AW:0]   a1_r;
  logic signed [BW-1:0] base_o_r, base_n_r, base_d_r, base_k_r;
  logic [AW-1:0]        n_r, n_d_r;
  logic [AW:0]          m_r;
  logic [NW-1:0]        d_r, d_k_r, n_k_r;
  logic [KW-1:0]        k_c, k_r;
  logic [31:0]          ns_c, ds_c;

  always_comb begin
    k_c = '0;
    for (int p = 32; p < NW; p++) begin
      if (d_r[p]) begin
        k_c = KW'(p - 31);
      end
    end
  end

  assign ns_c = 32'(n_k_r >> k_r);
  assign ds_c = 32'(d_k_r >> k_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      // Clamp so that both corners of the cell stay on the grid.
      if (neg_r[QW]) begin
        qf_c_r <= '0;
      end else if (quo_r[QW] >= QMAX) begin
        qf_c_r <= QMAX[QB-1:0];
      end else begin
        qf_c_r <= quo_r[QW][QB-1:0];
      end
      dif_c_r <= dif_r[QW];

      prod_r  <= PW'(qf_c_r) * PW'(spc);
      qf_p_r  <= qf_c_r;
      dif_p_r <= dif_c_r;

      a0_r     <= AW'(dif_p_r) - AW'(prod_r);
      a1_r     <= (AW+1)'(spc) + (AW+1)'(prod_r) - (AW+1)'(dif_p_r);
      base_o_r <= BW'(org) + BW'(prod_r);
      qf_o_r   <= qf_p_r;

      n_r      <= a0_r[AW-1] ? AW'(-a0_r) : AW'(a0_r);
      m_r      <= a1_r[AW] ? (AW+1)'(-a1_r) : (AW+1)'(a1_r);
      base_n_r <= base_o_r;
      qf_n_r   <= qf_o_r;

      d_r      <= NW'(n_r) + NW'(m_r);
      n_d_r    <= n_r;
      base_d_r <= base_n_r;
      qf_d_r   <= qf_n_r;

      k_r      <= k_c;
      d_k_r    <= d_r;
      n_k_r    <= NW'(n_d_r);
      base_k_r <= base_d_r;
      qf_k_r   <= qf_d_r;
    end
  end

  // Far fraction: restoring division of n*2^30 + d/2 by d, one bit per stage.
  logic [FW-1:0]        fr_r [FQ];
  logic [31:0]          fd_r [FQ];
  logic [FQ-1:0]        fq_r [FQ+1];
  logic [QB-1:0]        qf_f_r [FQ+1];
  logic signed [BW-1:0] base_f_r [FQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      fr_r[0]     <= (FW'(ns_c) << WBITS) + FW'(ds_c >> 1);
      fd_r[0]     <= ds_c;
      fq_r[0]     <= '0;
      qf_f_r[0]   <= qf_k_r;
      base_f_r[0] <= base_k_r;
    end
  end

  for (genvar t = 1; t <= FQ; t++) begin : g_frac
    localparam int B = FQ - t;
    logic [FW-1:0] sub;
    logic          ge;
    assign sub = FW'(fd_r[t-1]) << B;
    assign ge  = fr_r[t-1] >= sub;
    always_ff @(posedge clk) begin
      if (adv) begin
        fq_r[t]     <= ge ? (fq_r[t-1] | (FQ'(1) << B)) : fq_r[t-1];
        qf_f_r[t]   <= qf_f_r[t-1];
        base_f_r[t] <= base_f_r[t-1];
      end
    end
    if (t < FQ) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          fr_r[t] <= ge ? fr_r[t-1] - sub : fr_r[t-1];
          fd_r[t] <= fd_r[t-1];
        end
      end
    end
  end

  assign qf_o   = qf_f_r[FQ];
  assign base_o = base_f_r[FQ];
  assign frac_o = fq_r[FQ];

endmodule
`default_nettype wire

// ===== design/gcs_front.sv =====
`default_nettype none
module gcs_front
  import gcs_pkg::*;
#(
  parameter int GRID_DIM = 1024,
  localparam int QB = $clog2(GRID_DIM),
  localparam int BW = QB + 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  input  logic signed [31:0]   org [3],
  input  logic [30:0]          spc [3],
  output logic                 a_valid,
  input  logic                 a_ready,
  output logic [QB-1:0]        a_qf [3],
  output logic signed [BW-1:0] a_base [3],
  output logic [30:0]          a_frac [3],
  output logic signed [31:0]   a_charge
);

  localparam int NS = QB + 40;

  logic [NS-1:0]      v_r;
  logic signed [31:0] chg_r [NS];
  logic signed [31:0] pos [3];
  logic               adv;

  // The whole pipeline holds when its last stage has an item that is not taken.
  assign adv      = !v_r[NS-1] || a_ready;
  assign in_ready = adv;
  assign a_valid  = v_r[NS-1];
  assign a_charge = chg_r[NS-1];

  assign pos[0] = in_data.atom_x;
  assign pos[1] = in_data.atom_y;
  assign pos[2] = in_data.atom_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chg_r[0] <= in_data.atom_charge;
      for (int i = 1; i < NS; i++) begin
        chg_r[i] <= chg_r[i-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    gcs_axis #(.GRID_DIM(GRID_DIM)) u_axis (
      .clk    (clk),
      .adv    (adv),
      .pos    (pos[a]),
      .org    (org[a]),
      .spc    (spc[a]),
      .qf_o   (a_qf[a]),
      .base_o (a_base[a]),
      .frac_o (a_frac[a])
    );
  end

endmodule
`default_nettype wire

// ===== design/gcs_corner.sv =====
`default_nettype none
module gcs_corner
  import gcs_pkg::*;
#(
  parameter int GRID_DIM = 1024,
  localparam int QB = $clog2(GRID_DIM),
  localparam int BW = QB + 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 a_valid,
  output logic                 a_ready,
  input  logic [QB-1:0]        a_qf [3],
  input  logic signed [BW-1:0] a_base [3],
  input  logic [30:0]          a_frac [3],
  input  logic signed [31:0]   a_charge,
  input  logic [30:0]          spc [3],
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int IW = $clog2(GRID_DIM + 1);

  // Holding register for one atom, walked through its eight corners.
  logic                 hv_r;
  logic [2:0]           cnt_r;
  logic [QB-1:0]        hq_r [3];
  logic signed [BW-1:0] hb_r [3];
  logic [30:0]          hf_r [3];
  logic signed [31:0]   hc_r;

  logic [3:0] v_r;
  logic       adv, take;

  assign adv     = !v_r[3] || out_ready;
  assign take    = hv_r && adv;
  assign a_ready = !hv_r || (take && cnt_r == LAST_CNR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r  <= 1'b0;
      cnt_r <= '0;
      v_r   <= '0;
    end else begin
      if (take) begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (a_valid && a_ready) begin
        hv_r <= 1'b1;
      end else if (take && cnt_r == LAST_CNR) begin
        hv_r <= 1'b0;
      end
      if (adv) begin
        v_r <= {v_r[2:0], hv_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      hq_r <= a_qf;
      hb_r <= a_base;
      hf_r <= a_frac;
      hc_r <= a_charge;
    end
  end

  // Corner selection: index, saturated coordinate and per-axis fraction.
  logic [IW-1:0]      ci_c [3];
  logic signed [31:0] crd_c [3];
  logic [30:0]        f_c [3];
  logic [31:0]        m_c;

  always_comb begin
    logic signed [BW:0] sum;
    for (int a = 0; a < 3; a++) begin
      ci_c[a] = IW'(hq_r[a]) + IW'(1) + IW'(cnt_r[a]);
      sum = (BW+1)'(hb_r[a]) + (cnt_r[a] ? (BW+1)'(spc[a]) : '0);
      if ((&sum[BW:31]) || !(|sum[BW:31])) begin
        crd_c[a] = sum[31:0];
      end else begin
        crd_c[a] = sum[BW] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      f_c[a] = cnt_r[a] ? hf_r[a] : ONE_W - hf_r[a];
    end
    m_c = hc_r[31] ? 32'd0 - 32'(hc_r) : 32'(hc_r);
  end

  logic [IW-1:0]      ci_r [4][3];
  logic signed [31:0] crd_r [4][3];
  logic [30:0]        f_r [3][3];
  logic [31:0]        m_r [4];
  logic [3:0]         sg_r, lst_r;
  logic [62:0]        pr_c [3];

  for (genvar s = 0; s < 3; s++) begin : g_mul
    assign pr_c[s] = 63'(m_r[s]) * 63'(f_r[s][s]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ci_r[0]  <= ci_c;
      crd_r[0] <= crd_c;
      f_r[0]   <= f_c;
      m_r[0]   <= m_c;
      sg_r[0]  <= hc_r[31];
      lst_r[0] <= cnt_r == LAST_CNR;
      for (int s = 1; s < 4; s++) begin
        ci_r[s]  <= ci_r[s-1];
        crd_r[s] <= crd_r[s-1];
        sg_r[s]  <= sg_r[s-1];
        lst_r[s] <= lst_r[s-1];
        // Scale by one axis per stage, rounding the magnitude half up.
        m_r[s]   <= 32'((64'(pr_c[s-1]) + HALF_W) >> WBITS);
      end
      f_r[1] <= f_r[0];
      f_r[2] <= f_r[1];
    end
  end

  assign out_valid = v_r[3];

  always_comb begin
    out_data.corner_i     = 11'(ci_r[3][0]);
    out_data.corner_j     = 11'(ci_r[3][1]);
    out_data.corner_k     = 11'(ci_r[3][2]);
    out_data.corner_x     = crd_r[3][0];
    out_data.corner_y     = crd_r[3][1];
    out_data.corner_z     = crd_r[3][2];
    out_data.corner_share = sg_r[3] ? 32'd0 - m_r[3] : m_r[3];
    out_data.last_corner  = lst_r[3];
  end

endmodule
`default_nettype wire

// ===== design/grid_charge_spreader.sv =====
// An accepted atom passes through the per-axis divider pipelines and the corner stage
// before its first corner item; the other seven corners follow one per cycle while
// out_ready is high. Throughput: the single result channel carries one corner item
// per cycle; the per-axis divider pipelines take an atom every cycle unless stalled.
// Reset (synchronous, rst_n low) empties all pipelines and sets origins to 0 and
// spacings to 1.0.
`default_nettype none
module grid_charge_spreader
  import gcs_pkg::*;
#(
  parameter int GRID_DIM  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int QB = $clog2(GRID_DIM);
  localparam int BW = QB + 33;
  localparam logic [30:0] SPC_RESET = 31'(64'(1) << FRAC_BITS);

  logic signed [31:0] org_r [3];
  logic [30:0]        spc_r [3];
  logic [30:0]        spc_w;

  // A zero spacing acts as the smallest step.
  assign spc_w     = (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        org_r[a] <= '0;
        spc_r[a] <= SPC_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X:  org_r[0] <= cfg_data;
        CFG_ORIGIN_Y:  org_r[1] <= cfg_data;
        CFG_ORIGIN_Z:  org_r[2] <= cfg_data;
        CFG_SPACING_X: spc_r[0] <= spc_w;
        CFG_SPACING_Y: spc_r[1] <= spc_w;
        CFG_SPACING_Z: spc_r[2] <= spc_w;
        default: ;
      endcase
    end
  end

  logic                 a_valid, a_ready;
  logic [QB-1:0]        a_qf [3];
  logic signed [BW-1:0] a_base [3];
  logic [30:0]          a_frac [3];
  logic signed [31:0]   a_charge;

  gcs_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .org      (org_r),
    .spc      (spc_r),
    .a_valid  (a_valid),
    .a_ready  (a_ready),
    .a_qf     (a_qf),
    .a_base   (a_base),
    .a_frac   (a_frac),
    .a_charge (a_charge)
  );

  gcs_corner #(.GRID_DIM(GRID_DIM)) u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid),
    .a_ready   (a_ready),
    .a_qf      (a_qf),
    .a_base    (a_base),
    .a_frac    (a_frac),
    .a_charge  (a_charge),
    .spc       (spc_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== design/gcs_checker.sv =====
`default_nettype none
module gcs_checker
  import gcs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic [2:0] ocnt_r;
  logic [7:0] pend_r;
  logic       in_acc, out_acc, atom_done;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign atom_done = out_acc && out_data.last_corner;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
      pend_r <= '0;
    end else begin
      if (out_acc) begin
        ocnt_r <= ocnt_r + 3'd1;
      end
      pend_r <= pend_r + 8'(in_acc) - 8'(atom_done);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_data.last_corner == (ocnt_r == LAST_CNR)))
    else $error("last corner flag out of step with the eight corners of an atom");

  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("corner item delivered with no atom outstanding");

  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.corner_i != '0 && out_data.corner_j != '0 &&
                   out_data.corner_k != '0))
    else $error("corner index of zero");

endmodule

bind grid_charge_spreader gcs_checker u_gcs_checker (.*);
`default_nettype wire
